[hdl/lact_pkg.sv]
package lact_pkg;

  // input item field widths and tdata positions
  localparam int FUNC_W      = 2;
  localparam int SET_W       = 6;
  localparam int WAY_W       = 2;
  localparam int TAG_W       = 20;
  localparam int OLD_AGE_W   = 2;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 8;

  localparam int SET_LSB     = 0;
  localparam int WAY_LSB     = SET_LSB + SET_W;
  localparam int TAG_LSB     = WAY_LSB + WAY_W;
  localparam int VALID_LSB   = TAG_LSB + TAG_W;
  localparam int OLD_AGE_LSB = VALID_LSB + 1;

  localparam int HIT_LSB     = 0;
  localparam int HIT_WAY_LSB = 1;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TOUCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // control for the per-way update unit
  typedef struct packed {
    logic wr;     // write entry in progress
    logic touch;  // touch in progress
    logic sel;    // current way is the addressed way
    logic vbit;   // valid value for write entry
  } unit_ctl_t;

endpackage

[hdl/lact_ram.sv]
module lact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/lact_way_unit.sv]
module lact_way_unit #(
  parameter int TAG_WIDTH = 20,
  parameter int AGE_W     = 2
) (
  input  lact_pkg::unit_ctl_t              ctl,
  input  logic [TAG_WIDTH-1:0]             key,
  input  logic [lact_pkg::OLD_AGE_W-1:0]   old_age,
  input  logic [TAG_WIDTH-1:0]             tag_cur,
  input  logic                             valid_cur,
  input  logic [AGE_W-1:0]                 age_cur,
  output logic [TAG_WIDTH-1:0]             tag_new,
  output logic                             valid_new,
  output logic [AGE_W-1:0]                 age_new,
  output logic                             match
);

  localparam int CMP_W = (AGE_W > lact_pkg::OLD_AGE_W) ? AGE_W : lact_pkg::OLD_AGE_W;

  always_comb begin
    match     = ctl.touch && valid_cur && (tag_cur == key);
    tag_new   = tag_cur;
    valid_new = valid_cur;
    age_new   = age_cur;
    if (ctl.wr && ctl.sel) begin
      tag_new   = key;
      valid_new = ctl.vbit;
    end
    if (match) begin
      age_new = '0;
    end else if (ctl.touch && (CMP_W'(age_cur) < CMP_W'(old_age))) begin
      // wraps at the age width
      age_new = age_cur + AGE_W'(1);
    end
  end

endmodule

[hdl/lru_age_counter_table_top.sv]
// Tag, valid and age store of a set-associative cache with counter-based LRU.
// Input channel: in_tuser carries the operation (write entry, touch, clear
// all), in_tdata the set, way, tag, valid value and previous age. Result
// channel: one item per input item; out_tdata holds hit and hit_way, both
// zero for anything but a touch that finds a valid matching way.
// Write entry and touch read one set row, run it through one per-way update
// unit, a way per cycle, and write the row back. Clear all sweeps the
// valid/age memory one set per cycle. Unused operation codes, an out-of-range
// set and an out-of-range way on a write entry give a zero result. No new
// item is taken until the last one is finished. After reset the block runs
// the same sweep, with no result, with in_tready low. One result register
// sits on the output: an item can be taken while a result waits, but the
// block holds its finished result in a final step until out_tready frees
// the register, and takes nothing more until then.
module lru_age_counter_table_top #(
  parameter int WAYS      = 4,
  parameter int SETS      = 64,
  parameter int TAG_WIDTH = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // set_index[5:0], way[7:6], tag[27:8], valid_bit[28], old_age[30:29], zero[31]
  input  logic [lact_pkg::IN_DATA_W-1:0]     in_tdata,
  // func[1:0]
  input  logic [lact_pkg::FUNC_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit[0], hit_way[2:1], zero[7:3]
  output logic [lact_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int AGE_W  = $clog2(WAYS);
  localparam int WCNT_W = $clog2(WAYS);
  localparam int SA_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SLOT_W = 1 + AGE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // input field slices
  logic [lact_pkg::SET_W-1:0]     in_set;
  logic [lact_pkg::WAY_W-1:0]     in_way;
  logic [lact_pkg::TAG_W-1:0]     in_tag;
  logic                           in_vbit;
  logic [lact_pkg::OLD_AGE_W-1:0] in_old_age;
  logic                           accept;
  logic                           set_ok;
  logic                           way_ok;

  assign in_set     = in_tdata[lact_pkg::SET_LSB +: lact_pkg::SET_W];
  assign in_way     = in_tdata[lact_pkg::WAY_LSB +: lact_pkg::WAY_W];
  assign in_tag     = in_tdata[lact_pkg::TAG_LSB +: lact_pkg::TAG_W];
  assign in_vbit    = in_tdata[lact_pkg::VALID_LSB];
  assign in_old_age = in_tdata[lact_pkg::OLD_AGE_LSB +: lact_pkg::OLD_AGE_W];
  assign set_ok     = (32'(in_set) < SETS);
  assign way_ok     = (32'(in_way) < WAYS);

  // registers
  logic [2:0]                     state_r, state_nxt;
  logic [lact_pkg::FUNC_W-1:0]    func_r, func_nxt;
  logic [lact_pkg::SET_W-1:0]     set_r, set_nxt;
  logic [lact_pkg::WAY_W-1:0]     way_r, way_nxt;
  logic [TAG_WIDTH-1:0]           key_r, key_nxt;
  logic                           vbit_r, vbit_nxt;
  logic [lact_pkg::OLD_AGE_W-1:0] old_age_r, old_age_nxt;
  logic [WCNT_W-1:0]              way_cnt_r, way_cnt_nxt;
  logic [SA_W-1:0]                set_cnt_r, set_cnt_nxt;
  logic                           clr_reply_r, clr_reply_nxt;
  logic                           hit_r, hit_nxt;
  logic [WCNT_W-1:0]              hit_way_r, hit_way_nxt;
  logic [TAG_WIDTH-1:0]           tag_row_r [WAYS];
  logic [TAG_WIDTH-1:0]           tag_row_nxt [WAYS];
  logic                           valid_row_r [WAYS];
  logic                           valid_row_nxt [WAYS];
  logic [AGE_W-1:0]               age_row_r [WAYS];
  logic [AGE_W-1:0]               age_row_nxt [WAYS];
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic                           out_hit_r, out_hit_nxt;
  logic [lact_pkg::WAY_W-1:0]     out_hit_way_r, out_hit_way_nxt;

  // memories
  logic [SA_W-1:0]                set_addr;
  logic                           tag_we;
  logic                           st_we;
  logic [SA_W-1:0]                st_waddr;
  logic [WAYS*TAG_WIDTH-1:0]      tag_wdata;
  logic [WAYS*TAG_WIDTH-1:0]      tag_rdata;
  logic [WAYS*SLOT_W-1:0]         st_wdata;
  logic [WAYS*SLOT_W-1:0]         st_rdata;

  // shared update unit
  lact_pkg::unit_ctl_t            ctl;
  logic [TAG_WIDTH-1:0]           u_tag;
  logic                           u_valid;
  logic [AGE_W-1:0]               u_age;
  logic                           u_match;

  assign set_addr = SA_W'(set_r);

  lact_ram #(
    .WIDTH (WAYS*TAG_WIDTH),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk     (clk),
    .we      (tag_we),
    .waddr   (set_addr),
    .wdata   (tag_wdata),
    .raddr   (set_addr),
    .rd_data (tag_rdata)
  );

  lact_ram #(
    .WIDTH (WAYS*SLOT_W),
    .DEPTH (SETS)
  ) u_state_ram (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr   (set_addr),
    .rd_data (st_rdata)
  );

  assign ctl.wr    = (func_r == lact_pkg::FUNC_WRITE);
  assign ctl.touch = (func_r == lact_pkg::FUNC_TOUCH);
  assign ctl.sel   = (32'(way_cnt_r) == 32'(way_r));
  assign ctl.vbit  = vbit_r;

  // always works on slot 0 of the rotating row buffer
  lact_way_unit #(
    .TAG_WIDTH (TAG_WIDTH),
    .AGE_W     (AGE_W)
  ) u_way_unit (
    .ctl       (ctl),
    .key       (key_r),
    .old_age   (old_age_r),
    .tag_cur   (tag_row_r[0]),
    .valid_cur (valid_row_r[0]),
    .age_cur   (age_row_r[0]),
    .tag_new   (u_tag),
    .valid_new (u_valid),
    .age_new   (u_age),
    .match     (u_match)
  );

  always_comb begin
    tag_we   = (state_r == ST_WB);
    st_we    = (state_r == ST_WB) || (state_r == ST_CLR);
    st_waddr = (state_r == ST_CLR) ? set_cnt_r : set_addr;
    for (int w = 0; w < WAYS; w++) begin
      tag_wdata[w*TAG_WIDTH +: TAG_WIDTH] = tag_row_r[w];
      if (state_r == ST_CLR) begin
        st_wdata[w*SLOT_W +: SLOT_W] = {1'b0, {AGE_W{1'b1}}};
      end else begin
        st_wdata[w*SLOT_W +: SLOT_W] = {valid_row_r[w], age_row_r[w]};
      end
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    set_nxt         = set_r;
    way_nxt         = way_r;
    key_nxt         = key_r;
    vbit_nxt        = vbit_r;
    old_age_nxt     = old_age_r;
    way_cnt_nxt     = way_cnt_r;
    set_cnt_nxt     = set_cnt_r;
    clr_reply_nxt   = clr_reply_r;
    hit_nxt         = hit_r;
    hit_way_nxt     = hit_way_r;
    tag_row_nxt     = tag_row_r;
    valid_row_nxt   = valid_row_r;
    age_row_nxt     = age_row_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_hit_nxt     = out_hit_r;
    out_hit_way_nxt = out_hit_way_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt    = in_tuser;
          set_nxt     = in_set;
          way_nxt     = in_way;
          key_nxt     = TAG_WIDTH'(in_tag);
          vbit_nxt    = in_vbit;
          old_age_nxt = in_old_age;
          hit_nxt     = 1'b0;
          hit_way_nxt = '0;
          way_cnt_nxt = '0;
          priority if (in_tuser == lact_pkg::FUNC_CLEAR) begin
            set_cnt_nxt   = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = ST_CLR;
          end else if (((in_tuser == lact_pkg::FUNC_TOUCH) && set_ok) ||
                       ((in_tuser == lact_pkg::FUNC_WRITE) && set_ok && way_ok)) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        for (int w = 0; w < WAYS; w++) begin
          tag_row_nxt[w]   = tag_rdata[w*TAG_WIDTH +: TAG_WIDTH];
          valid_row_nxt[w] = st_rdata[w*SLOT_W + AGE_W];
          age_row_nxt[w]   = st_rdata[w*SLOT_W +: AGE_W];
        end
        way_cnt_nxt = '0;
        state_nxt   = ST_WALK;
      end
      ST_WALK: begin
        // rotate: after WAYS steps the row is back in way order
        for (int w = 0; w < WAYS - 1; w++) begin
          tag_row_nxt[w]   = tag_row_r[w+1];
          valid_row_nxt[w] = valid_row_r[w+1];
          age_row_nxt[w]   = age_row_r[w+1];
        end
        tag_row_nxt[WAYS-1]   = u_tag;
        valid_row_nxt[WAYS-1] = u_valid;
        age_row_nxt[WAYS-1]   = u_age;
        if (u_match && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_way_nxt = way_cnt_r;
        end
        way_cnt_nxt = way_cnt_r + WCNT_W'(1);
        if (way_cnt_r == WCNT_W'(WAYS - 1)) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        state_nxt = ST_DONE;
      end
      ST_CLR: begin
        set_cnt_nxt = set_cnt_r + SA_W'(1);
        if (set_cnt_r == SA_W'(SETS - 1)) begin
          state_nxt = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt  = 1'b1;
          out_hit_nxt     = hit_r;
          out_hit_way_nxt = lact_pkg::WAY_W'(hit_way_r);
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      set_cnt_r    <= '0;
      clr_reply_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      hit_r        <= 1'b0;
      hit_way_r    <= '0;
      way_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      set_cnt_r    <= set_cnt_nxt;
      clr_reply_r  <= clr_reply_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      hit_r        <= hit_nxt;
      hit_way_r    <= hit_way_nxt;
      way_cnt_r    <= way_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    set_r         <= set_nxt;
    way_r         <= way_nxt;
    key_r         <= key_nxt;
    vbit_r        <= vbit_nxt;
    old_age_r     <= old_age_nxt;
    tag_row_r     <= tag_row_nxt;
    valid_row_r   <= valid_row_nxt;
    age_row_r     <= age_row_nxt;
    out_hit_r     <= out_hit_nxt;
    out_hit_way_r <= out_hit_way_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(lact_pkg::OUT_DATA_W - 1 - lact_pkg::WAY_W){1'b0}},
                       out_hit_way_r, out_hit_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("block still ready after taking an item");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!st_we && !tag_we))
    else $error("memory written while idle");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (32'(way_cnt_r) < WAYS))
    else $error("way counter past last way");

  a_miss_way_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !hit_r |-> (hit_way_r == '0))
    else $error("hit way set without a hit");

  a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (32'(set_cnt_r) < SETS))
    else $error("clear sweep past last set");

endmodule

[sim/lact_checker.sv]
module lact_checker
  import lact_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    pending
);

  localparam int NWAYS = 4;
  localparam int NSETS = 64;
  localparam int LINES = NSETS * NWAYS;
  localparam logic [OLD_AGE_W-1:0] AGE_OLDEST = '1;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
  } lookup_t;

  logic [TAG_W-1:0]     tag_mem   [LINES];
  logic                 valid_mem [LINES];
  logic [OLD_AGE_W-1:0] age_mem   [LINES];
  lookup_t              lookup_q  [$];
  lookup_t              want;

  function automatic void clear_lines();
    for (int i = 0; i < LINES; i++) begin
      valid_mem[i] = 1'b0;
      age_mem[i]   = AGE_OLDEST;
    end
  endfunction

  // applies one item to the shadow store and returns the lookup outcome
  function automatic lookup_t apply_op(input logic [FUNC_W-1:0] fn,
                                       input logic [IN_DATA_W-1:0] d);
    lookup_t              r = '0;
    int                   base;
    int                   e;
    logic [TAG_W-1:0]     t;
    logic [OLD_AGE_W-1:0] prev_age;
    base     = int'(d[SET_LSB +: SET_W]) * NWAYS;
    t        = d[TAG_LSB +: TAG_W];
    prev_age = d[OLD_AGE_LSB +: OLD_AGE_W];
    case (fn)
      FUNC_WRITE: begin
        e = base + int'(d[WAY_LSB +: WAY_W]);
        tag_mem[e]   = t;
        valid_mem[e] = d[VALID_LSB];
      end
      FUNC_TOUCH: begin
        for (int w = 0; w < NWAYS; w++) begin
          e = base + w;
          // valid is tested first, so a never-written tag is never compared
          if (valid_mem[e] && tag_mem[e] == t) begin
            age_mem[e] = '0;
            if (!r.hit) begin
              r.hit     = 1'b1;
              r.hit_way = WAY_W'(w);
            end
          end else if (age_mem[e] < prev_age) begin
            age_mem[e] = age_mem[e] + 1'b1;
          end
        end
      end
      FUNC_CLEAR: clear_lines();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input int exp_val, input int got_val);
    $display("lact_check: %s: expected %0d, got %0d at %0t", what, exp_val, got_val,
             $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_lines();
      foreach (tag_mem[i]) tag_mem[i] = '0;
      lookup_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (lookup_q.size() == 0) begin
          report("result item with nothing pending", 0, int'(out_tdata));
        end else begin
          want = lookup_q.pop_front();
          if (out_tdata[HIT_LSB] !== want.hit)
            report("hit", int'(want.hit), int'(out_tdata[HIT_LSB]));
          if (out_tdata[HIT_WAY_LSB +: WAY_W] !== want.hit_way)
            report("hit_way", int'(want.hit_way), int'(out_tdata[HIT_WAY_LSB +: WAY_W]));
          if (out_tdata[OUT_DATA_W-1:HIT_WAY_LSB+WAY_W] !== '0)
            report("padding", 0, int'(out_tdata[OUT_DATA_W-1:HIT_WAY_LSB+WAY_W]));
        end
      end
      if (in_tvalid && in_tready)
        lookup_q.push_back(apply_op(in_tuser, in_tdata));
    end
    pending = lookup_q.size();
  end

endmodule

[sim/lru_age_counter_table_top_test.sv]
module lru_age_counter_table_top_test;
  import lact_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEMS          = 550;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatches;
  int                    pending;

  // which ways of each set hold a written tag; touches only go to full sets
  bit [3:0]         way_written [64];
  logic [TAG_W-1:0] tag_pool    [8];
  int               hot_set     [8];
  int               in_calm  = 0;
  int               out_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_age_counter_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lact_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // result side backpressure: short stalls, a few long ones, some calm runs
  always @(negedge clk) begin : ready_gen
    int r;
    if (out_hold > 0) begin
      out_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_tready = 1'b1;
        out_hold   = $urandom_range(0, 8);
      end else if (r < 90) begin
        out_tready = 1'b0;
        out_hold   = $urandom_range(0, 3);
      end else if (r < 96) begin
        out_tready = 1'b0;
        out_hold   = $urandom_range(10, 40);
      end else begin
        out_tready = 1'b1;
        out_hold   = $urandom_range(50, 150);
      end
    end
  end

  function automatic int in_gap();
    int r;
    if (in_calm > 0) begin
      in_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      in_calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [SET_W-1:0] set_idx,
                           input logic [WAY_W-1:0] way, input logic [TAG_W-1:0] tag,
                           input logic vbit, input logic [OLD_AGE_W-1:0] prev_age);
    int gap;
    gap = in_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = fn;
    in_tdata  = {1'b0, prev_age, vbit, tag, way, set_idx};
    in_tvalid = 1'b1;
    if (fn == FUNC_WRITE) way_written[set_idx][way] = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_op();
    int               r;
    logic [SET_W-1:0] s;
    logic [WAY_W-1:0] w;
    logic [TAG_W-1:0] t;
    r = $urandom_range(0, 99);
    s = SET_W'(($urandom_range(0, 9) < 9) ? hot_set[$urandom_range(0, 7)]
                                          : $urandom_range(0, 63));
    t = ($urandom_range(0, 4) < 4) ? tag_pool[$urandom_range(0, 7)] : TAG_W'($urandom());
    w = WAY_W'($urandom_range(0, 3));
    if (r < 2) begin
      send_item(FUNC_CLEAR, s, w, t, 1'($urandom_range(0, 1)),
                OLD_AGE_W'($urandom_range(0, 3)));
    end else if (r < 4) begin
      send_item(FUNC_UNUSED, s, w, t, 1'($urandom_range(0, 1)),
                OLD_AGE_W'($urandom_range(0, 3)));
    end else if (r < 40 || way_written[s] != 4'hf) begin
      // a touch on a partly written set becomes a write of a missing way
      if (r >= 40) while (way_written[s][w]) w = w + 1'b1;
      send_item(FUNC_WRITE, s, w, t, $urandom_range(0, 3) != 0,
                OLD_AGE_W'($urandom_range(0, 3)));
    end else begin
      send_item(FUNC_TOUCH, s, w, t, 1'($urandom_range(0, 1)),
                OLD_AGE_W'($urandom_range(0, 3)));
    end
  endtask

  initial begin : watchdog
    int idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("lru_age_counter_table_top: mismatch");
    $finish;
  end

  initial begin
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = TAG_W'($urandom());
    hot_set[0] = 0;
    hot_set[1] = 63;
    for (int i = 2; i < 8; i++) hot_set[i] = $urandom_range(0, 63);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, duplicate tags, miss with aging, clear, unused code
    send_item(FUNC_CLEAR, 6'd0, 2'd0, 20'h00000, 1'b0, 2'd0);
    send_item(FUNC_WRITE, 6'd0, 2'd0, 20'h00000, 1'b1, 2'd0);
    send_item(FUNC_WRITE, 6'd0, 2'd1, 20'hfffff, 1'b1, 2'd3);
    send_item(FUNC_WRITE, 6'd0, 2'd2, 20'hfffff, 1'b1, 2'd0);
    send_item(FUNC_WRITE, 6'd0, 2'd3, 20'h5a5a5, 1'b0, 2'd0);
    send_item(FUNC_WRITE, 6'd63, 2'd0, 20'ha5a5a, 1'b1, 2'd0);
    send_item(FUNC_WRITE, 6'd63, 2'd1, 20'h12345, 1'b1, 2'd0);
    send_item(FUNC_WRITE, 6'd63, 2'd2, 20'hfedcb, 1'b1, 2'd0);
    send_item(FUNC_WRITE, 6'd63, 2'd3, 20'hfffff, 1'b1, 2'd0);
    send_item(FUNC_TOUCH, 6'd0, 2'd0, 20'hfffff, 1'b0, 2'd3);
    send_item(FUNC_TOUCH, 6'd0, 2'd0, 20'h00000, 1'b0, 2'd0);
    send_item(FUNC_TOUCH, 6'd0, 2'd3, 20'h5a5a5, 1'b0, 2'd2);
    send_item(FUNC_TOUCH, 6'd63, 2'd3, 20'hfffff, 1'b1, 2'd3);
    send_item(FUNC_TOUCH, 6'd63, 2'd0, 20'h0f0f0, 1'b0, 2'd1);
    send_item(FUNC_TOUCH, 6'd63, 2'd1, 20'h12345, 1'b0, 2'd3);
    send_item(FUNC_UNUSED, 6'd63, 2'd3, 20'hfffff, 1'b1, 2'd3);
    send_item(FUNC_CLEAR, 6'd63, 2'd3, 20'hfffff, 1'b1, 2'd3);
    send_item(FUNC_TOUCH, 6'd0, 2'd0, 20'h00000, 1'b0, 2'd3);
    send_item(FUNC_WRITE, 6'd0, 2'd0, 20'h00000, 1'b1, 2'd0);
    send_item(FUNC_TOUCH, 6'd0, 2'd0, 20'h00000, 1'b0, 2'd3);
    send_item(FUNC_TOUCH, 6'd0, 2'd0, 20'h00000, 1'b0, 2'd0);

    repeat (ITEMS) random_op();
    @(negedge clk);
    in_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("lru_age_counter_table_top: match");
    end else begin
      $display("lru_age_counter_table_top: mismatch");
    end
    $finish;
  end

endmodule
